// ===== sv/assert_macros.svh =====
// assertion helpers used by the etas_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define ETAS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define ETAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/etas_pkg.sv =====
package etas_pkg;

    // number of live table entries, 1 to 8
    localparam int ENTRIES = 8;
    localparam int TABLE_DEPTH = 8;

    localparam logic [7:0] ENTRY_MASK = 8'((16'd1 << ENTRIES) - 16'd1);
    localparam logic [15:0] VOID_EVENT = 16'hFFFF;

    // configuration index space
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGS = CFG_IDX_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_TRIGGER   = 3'd1,
        OP_PROGRESS  = 3'd2,
        OP_TIMER     = 3'd3,
        OP_ABORT     = 3'd4,
        OP_TERMINATE = 3'd5,
        OP_QUERY     = 3'd6,
        OP_SPARE     = 3'd7
    } op_t;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_WAIT = 2'd1;
    localparam logic [1:0] ACT_SEND = 2'd2;

    // one table entry as packed in its configuration word
    typedef struct packed {
        logic [15:0] wait_time;
        logic [15:0] send_event;
        logic [7:0]  start_mask;
        logic [7:0]  sender;
        logic [15:0] recv_event;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_next;
    } status_t;

endpackage

// ===== sv/event_trigger_action_sequencer.sv =====
// channel    | handshake            | payload
// -----------+----------------------+---------------------------------------------
// config     | cfg_valid/cfg_ready  | cfg_index, cfg_data
// item in    | s_valid/s_ready      | s_op, s_recv_event, s_sender, s_timer_index
// result out | m_valid/m_ready      | m_action, m_entry_index, m_send_event,
//            |                      | m_wait_time, m_all_done, m_active, m_last
//
// an item is captured, then applied, then hands out its results; the result count
// is set by the serial walk over pending entries
// a new item is taken once the last result of the previous one is in the
// output register, even if that transfer has not completed
// aresetn is synchronous, active low: table, masks and running flag clear
// a stalled m_ready holds the result register and pauses the walk
module event_trigger_action_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [etas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_op,
    input  logic [15:0]                    s_recv_event,
    input  logic [7:0]                     s_sender,
    input  logic [2:0]                     s_timer_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_action,
    output logic [2:0]                     m_entry_index,
    output logic [15:0]                    m_send_event,
    output logic [15:0]                    m_wait_time,
    output logic                           m_all_done,
    output logic                           m_active,
    output logic                           m_last
);

    etas_pkg::cmd_t    cmd;
    etas_pkg::status_t status;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    etas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    etas_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_op          (s_op),
        .s_recv_event  (s_recv_event),
        .s_sender      (s_sender),
        .s_timer_index (s_timer_index),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_entry_index (m_entry_index),
        .m_send_event  (m_send_event),
        .m_wait_time   (m_wait_time),
        .m_all_done    (m_all_done),
        .m_active      (m_active),
        .m_last        (m_last)
    );

endmodule

// ===== sv/etas_ctrl.sv =====
module etas_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  etas_pkg::status_t status,
    output etas_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // sequencing of one item: take, apply, hand out results
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_next) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/etas_datapath.sv =====
module etas_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [etas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic [2:0]                        s_op,
    input  logic [15:0]                       s_recv_event,
    input  logic [7:0]                        s_sender,
    input  logic [2:0]                        s_timer_index,
    input  etas_pkg::cmd_t                    cmd,
    output etas_pkg::status_t                 status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_action,
    output logic [2:0]                        m_entry_index,
    output logic [15:0]                       m_send_event,
    output logic [15:0]                       m_wait_time,
    output logic                              m_all_done,
    output logic                              m_active,
    output logic                              m_last
);

    etas_pkg::entry_t entry_reg [etas_pkg::TABLE_DEPTH];

    logic [7:0]  trig_reg, trig_next;
    logic [7:0]  start_reg, start_next;
    logic        run_reg, run_next;
    logic [2:0]  op_reg;
    logic [15:0] ev_reg;
    logic [7:0]  snd_reg;
    logic [2:0]  ti_reg;
    logic [7:0]  pend_reg, pend_next;
    logic        timer_reg, timer_next;
    logic        done_reg;

    logic        m_valid_reg;
    logic [1:0]  m_action_reg;
    logic [2:0]  m_index_reg;
    logic [15:0] m_send_reg;
    logic [15:0] m_wait_reg;
    logic        m_done_reg;
    logic        m_active_reg;
    logic        m_last_reg;

    logic        found;
    logic [7:0]  elig;
    logic [7:0]  low_bit;
    logic [2:0]  low_idx;
    logic [15:0] sel_send;
    logic [15:0] sel_wait;
    logic        done_next;

    // apply the op to the masks and work out which entries will report
    always_comb begin
        trig_next = trig_reg;
        start_next = start_reg;
        run_next = run_reg;
        pend_next = '0;
        timer_next = 1'b0;
        elig = '0;
        found = 1'b0;
        case (etas_pkg::op_t'(op_reg))
            etas_pkg::OP_START: begin
                trig_next = '0;
                start_next = '0;
                run_next = 1'b1;
            end
            etas_pkg::OP_TRIGGER: begin
                if (run_reg) begin
                    for (int i = 0; i < etas_pkg::ENTRIES; i++) begin
                        if (!found && entry_reg[i].recv_event == ev_reg
                            && entry_reg[i].sender == snd_reg) begin
                            trig_next[i] = 1'b1;
                            found = 1'b1;
                        end
                    end
                end
            end
            etas_pkg::OP_ABORT: begin
                if (run_reg) begin
                    trig_next = trig_reg | (~start_reg & etas_pkg::ENTRY_MASK);
                end
            end
            etas_pkg::OP_TERMINATE: begin
                run_next = 1'b0;
            end
            etas_pkg::OP_TIMER: begin
                if (run_reg) begin
                    for (int i = 0; i < etas_pkg::ENTRIES; i++) begin
                        if (ti_reg == 3'(i)
                            && entry_reg[i].send_event != etas_pkg::VOID_EVENT) begin
                            pend_next[i] = 1'b1;
                            timer_next = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // progress pass, shared by start and progress
        if ((op_reg == etas_pkg::OP_START || op_reg == etas_pkg::OP_PROGRESS) && run_next) begin
            for (int i = 0; i < etas_pkg::ENTRIES; i++) begin
                if (!start_next[i]
                    && (trig_next & entry_reg[i].start_mask) == entry_reg[i].start_mask) begin
                    elig[i] = 1'b1;
                    if (entry_reg[i].wait_time != 16'd0
                        || entry_reg[i].send_event != etas_pkg::VOID_EVENT) begin
                        pend_next[i] = 1'b1;
                    end
                end
            end
            start_next = start_next | elig;
        end

        done_next = run_next ? (trig_next == etas_pkg::ENTRY_MASK) : 1'b1;
    end

    // lowest pending entry and its fields
    always_comb begin
        low_bit = pend_reg & (~pend_reg + 8'd1);
        low_idx = '0;
        sel_send = '0;
        sel_wait = '0;
        for (int i = 0; i < etas_pkg::TABLE_DEPTH; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | 3'(i);
                sel_send = sel_send | entry_reg[i].send_event;
                sel_wait = sel_wait | entry_reg[i].wait_time;
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign status.last_next = (pend_reg & ~low_bit) == 8'd0;

    // configuration table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < etas_pkg::TABLE_DEPTH; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_index < etas_pkg::CFG_REGS) begin
            entry_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_reg <= '0;
            start_reg <= '0;
            run_reg <= 1'b0;
            pend_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                trig_reg <= trig_next;
                start_reg <= start_next;
                run_reg <= run_next;
                pend_reg <= pend_next;
            end else if (cmd.emit) begin
                pend_reg <= pend_reg & ~low_bit;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and per-item flags
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg <= s_op;
            ev_reg <= s_recv_event;
            snd_reg <= s_sender;
            ti_reg <= s_timer_index;
        end
        if (cmd.exec) begin
            timer_reg <= timer_next;
            done_reg <= done_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_done_reg <= done_reg;
            m_active_reg <= run_reg;
            m_last_reg <= status.last_next;
            m_index_reg <= low_idx;
            if (pend_reg == 8'd0) begin
                m_action_reg <= etas_pkg::ACT_NONE;
                m_send_reg <= '0;
                m_wait_reg <= '0;
            end else if (!timer_reg && sel_wait != 16'd0) begin
                m_action_reg <= etas_pkg::ACT_WAIT;
                m_send_reg <= '0;
                m_wait_reg <= sel_wait;
            end else begin
                m_action_reg <= etas_pkg::ACT_SEND;
                m_send_reg <= sel_send;
                m_wait_reg <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_action = m_action_reg;
    assign m_entry_index = m_index_reg;
    assign m_send_event = m_send_reg;
    assign m_wait_time = m_wait_reg;
    assign m_all_done = m_done_reg;
    assign m_active = m_active_reg;
    assign m_last = m_last_reg;

endmodule

// ===== sv/etas_checker.sv =====
`include "assert_macros.svh"

module etas_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic [1:0]  m_action,
    input logic [2:0]  m_entry_index,
    input logic [15:0] m_send_event,
    input logic [15:0] m_wait_time,
    input logic        m_all_done,
    input logic        m_active,
    input logic        m_last
);

    // a status-only result carries no entry, event or wait
    `ETAS_ASSERT_NOW(a_status_clean, m_valid && m_action == etas_pkg::ACT_NONE, m_entry_index == 3'd0 && m_send_event == 16'd0 && m_wait_time == 16'd0)

    // a timer request carries no event and a send carries no wait
    `ETAS_ASSERT_NOW(a_action_fields, m_valid && m_action != etas_pkg::ACT_NONE, (m_action == etas_pkg::ACT_WAIT && m_send_event == 16'd0) || (m_action == etas_pkg::ACT_SEND && m_wait_time == 16'd0))

    // a stopped block always reports completion
    `ETAS_ASSERT_NOW(a_idle_done, m_valid && !m_active, m_all_done)

    // no new item while results of the current one are still to come
    `ETAS_ASSERT_NOW(a_no_overlap, m_valid && !m_last, !s_ready)

    // an accepted item is worked on before the next is taken
    `ETAS_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule

bind event_trigger_action_sequencer etas_checker u_etas_checker (.*);

// ===== test/etas_action_checker.sv =====
`timescale 1ns / 100ps

module etas_action_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [etas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [2:0]                     s_op,
    input  logic [15:0]                    s_recv_event,
    input  logic [7:0]                     s_sender,
    input  logic [2:0]                     s_timer_index,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [1:0]                     m_action,
    input  logic [2:0]                     m_entry_index,
    input  logic [15:0]                    m_send_event,
    input  logic [15:0]                    m_wait_time,
    input  logic                           m_all_done,
    input  logic                           m_active,
    input  logic                           m_last,
    output int                             fail_count,
    output int                             pending_count
);
    import etas_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  entry_index;
        logic [15:0] send_event;
        logic [15:0] wait_time;
        logic        all_done;
        logic        active;
        logic        last;
    } action_result_t;

    // shadow of the action table and the sequencer state
    entry_t         entry_tbl [TABLE_DEPTH];
    logic [7:0]     triggered;
    logic [7:0]     started;
    logic           running;

    action_result_t step_actions [$];
    action_result_t expected_actions [$];
    int             error_total;
    int             reported;

    function automatic void add_action(logic [1:0] act, logic [2:0] idx,
                                       logic [15:0] ev, logic [15:0] wt);
        action_result_t r;
        r = '0;
        r.action      = act;
        r.entry_index = idx;
        r.send_event  = ev;
        r.wait_time   = wt;
        step_actions.push_back(r);
    endfunction

    // start every pending entry whose start condition is met, lowest first
    function automatic void start_ready_entries();
        entry_t e;
        if (!running)
            return;
        for (int i = 0; i < ENTRIES; i++) begin
            e = entry_tbl[i];
            if (!started[i] && ((triggered & e.start_mask) == e.start_mask)) begin
                started[i] = 1'b1;
                if (e.wait_time != 16'd0)
                    add_action(ACT_WAIT, 3'(i), 16'd0, e.wait_time);
                else if (e.send_event != VOID_EVENT)
                    add_action(ACT_SEND, 3'(i), e.send_event, 16'd0);
            end
        end
    endfunction

    // work out the actions caused by one accepted item
    function automatic void predict_actions(op_t op, logic [15:0] ev, logic [7:0] snd,
                                            logic [2:0] ti);
        logic hit;
        logic done_flag;
        int   n;
        hit = 1'b0;
        case (op)
            OP_START: begin
                triggered = 8'd0;
                started   = 8'd0;
                running   = 1'b1;
                start_ready_entries();
            end
            OP_TRIGGER: begin
                if (running) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!hit && entry_tbl[i].recv_event == ev
                                && entry_tbl[i].sender == snd) begin
                            triggered[i] = 1'b1;
                            hit = 1'b1;
                        end
                    end
                end
            end
            OP_PROGRESS: start_ready_entries();
            OP_TIMER: begin
                if (running && int'(ti) < ENTRIES
                        && entry_tbl[ti].send_event != VOID_EVENT)
                    add_action(ACT_SEND, ti, entry_tbl[ti].send_event, 16'd0);
            end
            OP_ABORT: begin
                if (running)
                    triggered = triggered | (~started & ENTRY_MASK);
            end
            OP_TERMINATE: running = 1'b0;
            default: ;
        endcase

        // an item with no action still reports status once
        if (step_actions.size() == 0)
            add_action(ACT_NONE, 3'd0, 16'd0, 16'd0);

        done_flag = running ? (triggered == ENTRY_MASK) : 1'b1;
        n = step_actions.size();
        for (int k = 0; k < n; k++) begin
            step_actions[k].all_done = done_flag;
            step_actions[k].active   = running;
            step_actions[k].last     = (k == n - 1);
            expected_actions.push_back(step_actions[k]);
        end
        step_actions.delete();
    endfunction

    // compare one result transfer with the oldest expectation
    function automatic void check_result();
        action_result_t got;
        action_result_t want;
        got = {m_action, m_entry_index, m_send_event, m_wait_time,
               m_all_done, m_active, m_last};
        if (expected_actions.size() == 0) begin
            error_total++;
            if (reported < 10)
                $display("unexpected result: action %0d entry %0d send %h wait %h",
                         got.action, got.entry_index, got.send_event, got.wait_time);
            reported++;
            return;
        end
        want = expected_actions.pop_front();
        if (got !== want) begin
            error_total++;
            if (reported < 10) begin
                $display("mismatch: expected action %0d entry %0d send %h wait %h",
                         want.action, want.entry_index, want.send_event, want.wait_time);
                $display("          done %b active %b last %b",
                         want.all_done, want.active, want.last);
                $display("          got action %0d entry %0d send %h wait %h",
                         got.action, got.entry_index, got.send_event, got.wait_time);
                $display("          done %b active %b last %b",
                         got.all_done, got.active, got.last);
            end
            reported++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                entry_tbl[i] = '0;
            triggered   = 8'd0;
            started     = 8'd0;
            running     = 1'b0;
            error_total = 0;
            reported    = 0;
            expected_actions.delete();
            step_actions.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            // register writes beyond the table are dropped
            if (cfg_valid && cfg_ready && cfg_index < CFG_REGS)
                entry_tbl[cfg_index[2:0]] = cfg_data;
            if (s_valid && s_ready)
                predict_actions(op_t'(s_op), s_recv_event, s_sender, s_timer_index);
            fail_count    <= error_total;
            pending_count <= expected_actions.size();
        end
    end

endmodule

// ===== test/event_trigger_action_sequencer_tb.sv =====
`timescale 1ns / 100ps

module event_trigger_action_sequencer_tb;
    import etas_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    // table styles used by the random phases
    localparam int TBL_MIXED = 0;
    localparam int TBL_ZERO  = 1;
    localparam int TBL_ONES  = 2;
    localparam int TBL_NOISE = 3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [2:0]           s_op = '0;
    logic [15:0]          s_recv_event = '0;
    logic [7:0]           s_sender = '0;
    logic [2:0]           s_timer_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_action;
    logic [2:0]           m_entry_index;
    logic [15:0]          m_send_event;
    logic [15:0]          m_wait_time;
    logic                 m_all_done;
    logic                 m_active;
    logic                 m_last;

    int     fail_count;
    int     pending_count;
    int     cycle_count = 0;
    int     rx_hold = 0;
    bit     calm = 1'b0;
    entry_t tb_table [TABLE_DEPTH];

    always #10 aclk = ~aclk;

    event_trigger_action_sequencer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_recv_event  (s_recv_event),
        .s_sender      (s_sender),
        .s_timer_index (s_timer_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_entry_index (m_entry_index),
        .m_send_event  (m_send_event),
        .m_wait_time   (m_wait_time),
        .m_all_done    (m_all_done),
        .m_active      (m_active),
        .m_last        (m_last)
    );

    etas_action_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_recv_event  (s_recv_event),
        .s_sender      (s_sender),
        .s_timer_index (s_timer_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_action      (m_action),
        .m_entry_index (m_entry_index),
        .m_send_event  (m_send_event),
        .m_wait_time   (m_wait_time),
        .m_all_done    (m_all_done),
        .m_active      (m_active),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly short idle gaps, now and then a long one
    function automatic int idle_cycles();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_hold <= idle_cycles() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic entry_t pack_entry(logic [15:0] recv, logic [7:0] snd,
                                          logic [7:0] need, logic [15:0] send,
                                          logic [15:0] wt);
        return {wt, send, need, snd, recv};
    endfunction

    // one item transfer; valid stays high when the next item follows at once
    task automatic send_item(op_t op, logic [15:0] ev, logic [7:0] snd, logic [2:0] ti);
        s_valid       <= 1'b1;
        s_op          <= op;
        s_recv_event  <= ev;
        s_sender      <= snd;
        s_timer_index <= ti;
        do @(posedge aclk); while (!s_ready);
        if (!calm && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            repeat (idle_cycles()) @(posedge aclk);
        end
    endtask

    task automatic write_entry(logic [CFG_IDX_W-1:0] idx, logic [63:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // whole table plus writes to indexes past its end
    task automatic load_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            write_entry(CFG_IDX_W'(i), tb_table[i]);
        write_entry(CFG_IDX_W'(TABLE_DEPTH + $urandom_range(0, 7)), {$urandom, $urandom});
        write_entry('1, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // drain every expected result, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic build_table(int style);
        entry_t e;
        int     k;
        int     r;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            e = {$urandom, $urandom};
            if (style == TBL_ZERO) begin
                e = '0;
            end else if (style == TBL_ONES) begin
                e = '1;
            end else if (style == TBL_MIXED) begin
                // duplicate match keys now and then, lowest entry must win
                if (i > 0 && $urandom_range(0, 4) == 0) begin
                    k = $urandom_range(0, i - 1);
                    e.recv_event = tb_table[k].recv_event;
                    e.sender     = tb_table[k].sender;
                end
                r = $urandom_range(0, 3);
                if (r == 0)
                    e.start_mask = 8'd0;
                else if (r < 3)
                    e.start_mask = 8'($urandom) & 8'((1 << i) - 1);
                r = $urandom_range(0, 9);
                if (r < 5)
                    e.wait_time = 16'd0;
                else if (r == 9)
                    e.wait_time = 16'hFFFF;
                if ($urandom_range(0, 4) == 0)
                    e.send_event = VOID_EVENT;
            end
            tb_table[i] = e;
        end
    endtask

    // start, then mostly matching triggers and progress steps with some noise
    task automatic run_phase(int n_items);
        int          count;
        int          pick;
        int          k;
        logic [15:0] ev;
        logic [7:0]  snd;
        logic [2:0]  ti;
        count = 0;
        send_item(OP_START, 16'($urandom), 8'($urandom), 3'($urandom));
        while (count < n_items) begin
            ev   = 16'($urandom);
            snd  = 8'($urandom);
            ti   = 3'($urandom);
            k    = $urandom_range(0, ENTRIES - 1);
            pick = $urandom_range(0, 99);
            count++;
            if (pick < 36)
                send_item(OP_TRIGGER, tb_table[k].recv_event, tb_table[k].sender, ti);
            else if (pick < 60)
                send_item(OP_PROGRESS, ev, snd, ti);
            else if (pick < 72)
                send_item(OP_TIMER, ev, snd, ti);
            else if (pick < 77)
                send_item(OP_ABORT, ev, snd, ti);
            else if (pick < 79)
                send_item(OP_TERMINATE, ev, snd, ti);
            else if (pick < 86)
                send_item(OP_START, ev, snd, ti);
            else if (pick < 90)
                send_item(OP_QUERY, ev, snd, ti);
            else if (pick < 92)
                send_item(OP_SPARE, ev, snd, ti);
            else begin
                send_item(OP_TRIGGER, ev, snd, ti);
                count--;
            end
        end
    endtask

    initial begin
        int style;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle block on the reset table: nothing may happen
        send_item(OP_QUERY, 16'h0000, 8'h00, 3'd0);
        send_item(OP_TRIGGER, 16'h0000, 8'h00, 3'd0);
        send_item(OP_PROGRESS, 16'hFFFF, 8'hFF, 3'd7);
        send_item(OP_TIMER, 16'hFFFF, 8'hFF, 3'd0);
        send_item(OP_ABORT, 16'h0000, 8'h00, 3'd7);
        settle();

        // hand-built table covering chains, duplicates and void sends
        tb_table[0] = pack_entry(16'h0000, 8'h00, 8'h00, 16'h1234, 16'h0000);
        tb_table[1] = pack_entry(16'hFFFF, 8'hFF, 8'h01, 16'hABCD, 16'hFFFF);
        tb_table[2] = pack_entry(16'h1111, 8'h22, 8'h02, VOID_EVENT, 16'h0000);
        tb_table[3] = pack_entry(16'h1111, 8'h22, 8'h06, 16'h0000, 16'h0001);
        tb_table[4] = pack_entry(16'h5555, 8'h80, 8'h80, 16'hFFFE, 16'h0000);
        tb_table[5] = pack_entry(16'h5555, 8'h81, 8'h10, 16'h0F0F, 16'h00FF);
        tb_table[6] = pack_entry(16'hAAAA, 8'h55, 8'hFF, 16'h7777, 16'h0000);
        tb_table[7] = pack_entry(16'h8000, 8'h01, 8'h01, VOID_EVENT, 16'h8000);
        load_table();

        send_item(OP_START, 16'h0000, 8'h00, 3'd0);
        send_item(OP_TRIGGER, 16'h0000, 8'h00, 3'd0);
        send_item(OP_PROGRESS, 16'h0000, 8'h00, 3'd0);
        send_item(OP_TRIGGER, 16'h1111, 8'h22, 3'd0);
        send_item(OP_PROGRESS, 16'h0000, 8'h00, 3'd0);
        send_item(OP_TIMER, 16'h0000, 8'h00, 3'd1);
        send_item(OP_TIMER, 16'h0000, 8'h00, 3'd7);
        send_item(OP_TIMER, 16'h0000, 8'h00, 3'd2);
        send_item(OP_TIMER, 16'h0000, 8'h00, 3'd6);
        send_item(OP_TRIGGER, 16'hFFFF, 8'hFF, 3'd0);
        send_item(OP_TRIGGER, 16'h5555, 8'h82, 3'd0);
        send_item(OP_ABORT, 16'h0000, 8'h00, 3'd0);
        send_item(OP_PROGRESS, 16'h0000, 8'h00, 3'd0);
        send_item(OP_TRIGGER, 16'h8000, 8'h01, 3'd0);
        send_item(OP_PROGRESS, 16'h0000, 8'h00, 3'd0);
        send_item(OP_SPARE, 16'h0000, 8'h00, 3'd0);
        send_item(OP_TERMINATE, 16'h0000, 8'h00, 3'd0);
        send_item(OP_QUERY, 16'h0000, 8'h00, 3'd0);
        send_item(OP_START, 16'h0000, 8'h00, 3'd0);

        // random phases over several tables, extremes among them
        for (int p = 0; p < 7; p++) begin
            settle();
            style = (p == 1) ? TBL_ZERO : (p == 3) ? TBL_ONES :
                    (p == 4) ? TBL_NOISE : TBL_MIXED;
            calm = (p == 2 || p == 5);
            build_table(style);
            load_table();
            run_phase(24);
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
